@@ hw/rtl/tssv_pkg.sv @@
`default_nettype none
package tssv_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [5:0] HDR_LEN = 6'd8;
   localparam logic [5:0] CK_SHORT = 6'd9;
   localparam logic [5:0] CK_LEN = 6'd19;
   localparam logic [5:0] CK_END = 6'd35;
   localparam logic [5:0] CK_FULL = 6'd36;
   localparam logic [5:0] POS_MAX = 6'd63;
   localparam logic [13:0] YEAR_MIN = 14'd1900;
   localparam logic [13:0] YEAR_MAX = 14'd3000;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_CHECKSUM = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      logic hdr;
      logic hdr_dig;
      logic hdr_q;
      logic rec;
      logic rec_sl;
      logic rec_a;
      logic rec_b;
      logic ck9;
      logic ck;
   } flags_type;

   localparam flags_type FLAGS_INIT = '{hdr: 1'b1, hdr_dig: 1'b0, hdr_q: 1'b0, rec: 1'b1,
                                        rec_sl: 1'b0, rec_a: 1'b0, rec_b: 1'b0,
                                        ck9: 1'b1, ck: 1'b1};

   typedef struct packed {
      kind_type line_kind;
      logic line_ok;
      logic [11:0] rec_year;
      logic [3:0] rec_month;
      logic [4:0] rec_day;
      logic [63:0] upload_kb;
      logic [63:0] download_kb;
      logic mixed_count;
      logic is_verdict;
      logic snapshot_valid;
   } res_type;

   // The prime is 2^40 + 435, so the multiply is a shift plus a narrow constant product.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + x * 64'd435;
   endfunction

   // Returns the overflow-free flag above the new value.
   function automatic logic [64:0] acc_dec(input logic [63:0] v, input logic [3:0] d);
      logic [67:0] t;
      t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {64'd0, d};
      return {(t[67:64] == 4'd0), t[63:0]};
   endfunction

   function automatic logic [7:0] hdr_char(input logic [2:0] p);
      case (p)
         3'd0: hdr_char = 8'h6C;
         3'd1: hdr_char = 8'h69;
         3'd2: hdr_char = 8'h6E;
         3'd3: hdr_char = 8'h65;
         3'd4: hdr_char = 8'h73;
         3'd5: hdr_char = 8'h3A;
         3'd6: hdr_char = 8'h20;
         default: hdr_char = 8'h22;
      endcase
   endfunction

   function automatic logic [7:0] ck_char(input logic [4:0] p);
      case (p)
         5'd0: ck_char = 8'h63;
         5'd1: ck_char = 8'h68;
         5'd2: ck_char = 8'h65;
         5'd3: ck_char = 8'h63;
         5'd4: ck_char = 8'h6B;
         5'd5: ck_char = 8'h73;
         5'd6: ck_char = 8'h75;
         5'd7: ck_char = 8'h6D;
         5'd8: ck_char = 8'h3A;
         5'd9: ck_char = 8'h20;
         5'd10: ck_char = 8'h22;
         5'd11: ck_char = 8'h66;
         5'd12: ck_char = 8'h6E;
         5'd13: ck_char = 8'h76;
         5'd14: ck_char = 8'h31;
         5'd15: ck_char = 8'h61;
         5'd16: ck_char = 8'h36;
         5'd17: ck_char = 8'h34;
         5'd18: ck_char = 8'h3A;
         default: ck_char = 8'h00;
      endcase
   endfunction

   function automatic logic [6:0] days_in_month(input logic [6:0] m, input logic leap);
      case (m)
         7'd2: days_in_month = leap ? 7'd29 : 7'd28;
         7'd4, 7'd6, 7'd9, 7'd11: days_in_month = 7'd30;
         default: days_in_month = 7'd31;
      endcase
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tssv_req_if.sv @@
`default_nettype none
interface tssv_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic end_of_file;
   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tssv_rsp_if.sv @@
`default_nettype none
interface tssv_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] line_kind;
   logic line_ok;
   logic [11:0] rec_year;
   logic [3:0] rec_month;
   logic [4:0] rec_day;
   logic [63:0] upload_kb;
   logic [63:0] download_kb;
   logic mixed_count;
   logic is_verdict;
   logic snapshot_valid;
   modport source (output valid, output line_kind, output line_ok, output rec_year,
                   output rec_month, output rec_day, output upload_kb, output download_kb,
                   output mixed_count, output is_verdict, output snapshot_valid,
                   input ready);
   modport sink (input valid, input line_kind, input line_ok, input rec_year,
                 input rec_month, input rec_day, input upload_kb, input download_kb,
                 input mixed_count, input is_verdict, input snapshot_valid,
                 output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tssv_parse.sv @@
`default_nettype none
module tssv_parse (
   input wire logic clock,
   input wire logic reset,
   input wire logic take,
   input wire logic [7:0] data_byte,
   input wire logic end_of_file,
   output logic [1:0] res_count,
   output tssv_pkg::res_type res0,
   output tssv_pkg::res_type res1
);

   logic [5:0] pos_ff, pos_in;
   logic first_ff, first_in;
   logic hdrg_ff, hdrg_in;
   logic contg_ff, contg_in;
   logic cks_ff, cks_in;
   logic [63:0] exp_ff, exp_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [63:0] run_ff, run_in;
   logic [63:0] lh_ff, lh_in;
   logic [63:0] stored_ff, stored_in;
   logic [63:0] n1_ff, n1_in;
   logic [63:0] n2_ff, n2_in;
   logic [13:0] year_ff, year_in;
   logic [6:0] mon_ff, mon_in;
   logic [6:0] day_ff, day_in;
   tssv_pkg::flags_type flg_ff, flg_in;

   logic is_dig, is_lo_hex, is_up_hex, rok, leap, date_ok, rec_ok, hdr_ok;
   logic [3:0] hexv;
   logic [64:0] acc1, acc2;
   logic [63:0] lh_nl;
   tssv_pkg::flags_type tf;
   logic [63:0] t_n1, t_n2;
   logic [13:0] t_year;
   logic [6:0] t_mon, t_day;
   logic e_hdrg, e_contg, e_cks, verdict;
   logic [63:0] e_exp, e_cnt, e_run, e_stored;
   tssv_pkg::res_type el_res, rec_res, ver_res;

   assign is_dig = (data_byte >= 8'h30) && (data_byte <= 8'h39);
   assign is_lo_hex = (data_byte >= 8'h61) && (data_byte <= 8'h66);
   assign is_up_hex = (data_byte >= 8'h41) && (data_byte <= 8'h46);
   assign hexv = is_dig ? data_byte[3:0] : data_byte[3:0] + 4'd9;
   assign acc1 = tssv_pkg::acc_dec(n1_ff, data_byte[3:0]);
   assign acc2 = tssv_pkg::acc_dec(n2_ff, data_byte[3:0]);
   assign lh_nl = tssv_pkg::fnv_step(lh_ff, tssv_pkg::CHAR_LF);

   always_comb begin
      tf = flg_ff;
      t_n1 = n1_ff;
      t_n2 = n2_ff;
      t_year = year_ff;
      t_mon = mon_ff;
      t_day = day_ff;
      rok = 1'b1;
      if (tf.hdr) begin
         if (pos_ff < tssv_pkg::HDR_LEN) begin
            if (data_byte != tssv_pkg::hdr_char(pos_ff[2:0])) tf.hdr = 1'b0;
         end else if (tf.hdr_q) begin
            tf.hdr = 1'b0;
         end else if (is_dig) begin
            if (acc1[64]) begin
               t_n1 = acc1[63:0];
               tf.hdr_dig = 1'b1;
            end else begin
               tf.hdr = 1'b0;
            end
         end else if (data_byte == tssv_pkg::CHAR_QUOTE) begin
            tf.hdr_q = 1'b1;
         end else begin
            tf.hdr = 1'b0;
         end
      end
      if (tf.rec) begin
         if (pos_ff < 6'd4) begin
            if (is_dig) t_year = (year_ff << 3) + (year_ff << 1) + {10'd0, data_byte[3:0]};
            else rok = 1'b0;
         end else if (pos_ff == 6'd4 || pos_ff == 6'd7) begin
            rok = (data_byte == tssv_pkg::CHAR_SLASH);
         end else if (pos_ff == 6'd5 || pos_ff == 6'd6) begin
            if (is_dig) t_mon = (mon_ff << 3) + (mon_ff << 1) + {3'd0, data_byte[3:0]};
            else rok = 1'b0;
         end else if (pos_ff == 6'd8 || pos_ff == 6'd9) begin
            if (is_dig) t_day = (day_ff << 3) + (day_ff << 1) + {3'd0, data_byte[3:0]};
            else rok = 1'b0;
         end else if (pos_ff == 6'd10) begin
            rok = (data_byte == tssv_pkg::CHAR_SPACE);
         end else if (is_dig) begin
            if (tf.rec_sl) begin
               rok = acc2[64];
               if (acc2[64]) t_n2 = acc2[63:0];
               tf.rec_b = 1'b1;
            end else begin
               rok = acc1[64];
               if (acc1[64]) t_n1 = acc1[63:0];
               tf.rec_a = 1'b1;
            end
         end else if (data_byte == tssv_pkg::CHAR_SLASH) begin
            if (tf.rec_sl) rok = 1'b0;
            else tf.rec_sl = 1'b1;
         end else begin
            rok = 1'b0;
         end
         if (!rok) tf.rec = 1'b0;
      end
      if (tf.ck9 && pos_ff < tssv_pkg::CK_SHORT &&
          data_byte != tssv_pkg::ck_char(pos_ff[4:0])) begin
         tf.ck9 = 1'b0;
      end
      if (tf.ck) begin
         if (pos_ff < tssv_pkg::CK_LEN) begin
            if (data_byte != tssv_pkg::ck_char(pos_ff[4:0])) tf.ck = 1'b0;
         end else if (pos_ff < tssv_pkg::CK_END) begin
            if (is_dig || is_lo_hex || is_up_hex) t_n1 = {n1_ff[59:0], hexv};
            else tf.ck = 1'b0;
         end else if (pos_ff == tssv_pkg::CK_END) begin
            if (data_byte != tssv_pkg::CHAR_QUOTE) tf.ck = 1'b0;
         end else begin
            tf.ck = 1'b0;
         end
      end
   end

   // Leap centuries inside the allowed year range are 2000, 2400 and 2800.
   always_comb begin
      leap = (year_ff[1:0] == 2'd0) &&
             !(year_ff == 14'd1900 || year_ff == 14'd2100 || year_ff == 14'd2200 ||
               year_ff == 14'd2300 || year_ff == 14'd2500 || year_ff == 14'd2600 ||
               year_ff == 14'd2700 || year_ff == 14'd2900 || year_ff == 14'd3000);
      date_ok = (year_ff >= tssv_pkg::YEAR_MIN) && (year_ff <= tssv_pkg::YEAR_MAX) &&
                (mon_ff >= 7'd1) && (mon_ff <= 7'd12) && (day_ff >= 7'd1) &&
                (day_ff <= tssv_pkg::days_in_month(mon_ff, leap));
      rec_ok = flg_ff.rec && date_ok &&
               (flg_ff.rec_sl ? (flg_ff.rec_a && flg_ff.rec_b) : flg_ff.rec_a);
      hdr_ok = flg_ff.hdr && flg_ff.hdr_q && flg_ff.hdr_dig;

      rec_res = '0;
      rec_res.line_kind = tssv_pkg::KIND_RECORD;
      rec_res.line_ok = 1'b1;
      rec_res.rec_year = year_ff[11:0];
      rec_res.rec_month = mon_ff[3:0];
      rec_res.rec_day = day_ff[4:0];
      rec_res.upload_kb = flg_ff.rec_sl ? n1_ff : 64'd0;
      rec_res.download_kb = flg_ff.rec_sl ? n2_ff : n1_ff;
      rec_res.mixed_count = !flg_ff.rec_sl;

      el_res = '0;
      e_hdrg = hdrg_ff;
      e_contg = contg_ff;
      e_cks = cks_ff;
      e_exp = exp_ff;
      e_cnt = cnt_ff;
      e_run = run_ff;
      e_stored = stored_ff;
      if (first_ff) begin
         if (hdr_ok) begin
            e_hdrg = 1'b1;
            e_exp = n1_ff;
            el_res.line_kind = tssv_pkg::KIND_HEADER;
            el_res.line_ok = 1'b1;
         end else if (rec_ok) begin
            e_cnt = cnt_ff + 64'd1;
            el_res = rec_res;
         end else begin
            e_contg = 1'b0;
            el_res.line_kind = tssv_pkg::KIND_REJECT;
         end
      end else if (flg_ff.ck9 && pos_ff >= tssv_pkg::CK_SHORT) begin
         el_res.line_kind = tssv_pkg::KIND_CHECKSUM;
         if (cks_ff || !(flg_ff.ck && pos_ff == tssv_pkg::CK_FULL)) begin
            e_contg = 1'b0;
         end else begin
            e_stored = n1_ff;
            el_res.line_ok = 1'b1;
         end
         e_cks = 1'b1;
      end else if (!cks_ff && rec_ok) begin
         e_cnt = cnt_ff + 64'd1;
         if (hdrg_ff) e_run = lh_nl;
         el_res = rec_res;
      end else begin
         e_contg = 1'b0;
         el_res.line_kind = tssv_pkg::KIND_REJECT;
      end

      if (pos_ff != 6'd0) begin
         verdict = e_hdrg && e_contg && e_cks && (e_cnt == e_exp) && (e_run == e_stored);
      end else begin
         verdict = hdrg_ff && contg_ff && cks_ff && (cnt_ff == exp_ff) &&
                   (run_ff == stored_ff);
      end
      ver_res = '0;
      ver_res.is_verdict = 1'b1;
      ver_res.snapshot_valid = verdict;
   end

   always_comb begin
      res_count = 2'd0;
      res0 = el_res;
      res1 = ver_res;
      if (take) begin
         if (end_of_file) begin
            if (pos_ff != 6'd0) begin
               res_count = 2'd2;
            end else begin
               res_count = 2'd1;
               res0 = ver_res;
            end
         end else if (data_byte == tssv_pkg::CHAR_LF) begin
            res_count = 2'd1;
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      first_in = first_ff;
      hdrg_in = hdrg_ff;
      contg_in = contg_ff;
      cks_in = cks_ff;
      exp_in = exp_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      lh_in = lh_ff;
      stored_in = stored_ff;
      n1_in = n1_ff;
      n2_in = n2_ff;
      year_in = year_ff;
      mon_in = mon_ff;
      day_in = day_ff;
      flg_in = flg_ff;
      if (reset || (take && end_of_file)) begin
         pos_in = 6'd0;
         first_in = 1'b1;
         hdrg_in = 1'b0;
         contg_in = 1'b1;
         cks_in = 1'b0;
         exp_in = 64'd0;
         cnt_in = 64'd0;
         run_in = tssv_pkg::FNV_BASIS;
         lh_in = tssv_pkg::FNV_BASIS;
         stored_in = 64'd0;
         n1_in = 64'd0;
         n2_in = 64'd0;
         year_in = 14'd0;
         mon_in = 7'd0;
         day_in = 7'd0;
         flg_in = tssv_pkg::FLAGS_INIT;
      end else if (take && data_byte == tssv_pkg::CHAR_LF) begin
         first_in = 1'b0;
         hdrg_in = e_hdrg;
         contg_in = e_contg;
         cks_in = e_cks;
         exp_in = e_exp;
         cnt_in = e_cnt;
         run_in = e_run;
         stored_in = e_stored;
         pos_in = 6'd0;
         lh_in = e_run;
         n1_in = 64'd0;
         n2_in = 64'd0;
         year_in = 14'd0;
         mon_in = 7'd0;
         day_in = 7'd0;
         flg_in = tssv_pkg::FLAGS_INIT;
      end else if (take) begin
         pos_in = (pos_ff < tssv_pkg::POS_MAX) ? pos_ff + 6'd1 : pos_ff;
         lh_in = tssv_pkg::fnv_step(lh_ff, data_byte);
         n1_in = t_n1;
         n2_in = t_n2;
         year_in = t_year;
         mon_in = t_mon;
         day_in = t_day;
         flg_in = tf;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      first_ff <= first_in;
      hdrg_ff <= hdrg_in;
      contg_ff <= contg_in;
      cks_ff <= cks_in;
      exp_ff <= exp_in;
      cnt_ff <= cnt_in;
      run_ff <= run_in;
      lh_ff <= lh_in;
      stored_ff <= stored_in;
      n1_ff <= n1_in;
      n2_ff <= n2_in;
      year_ff <= year_in;
      mon_ff <= mon_in;
      day_ff <= day_in;
      flg_ff <= flg_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/tssv_rspq.sv @@
`default_nettype none
module tssv_rspq (
   input wire logic clock,
   input wire logic reset,
   input wire logic [1:0] push_count,
   input wire tssv_pkg::res_type push0,
   input wire tssv_pkg::res_type push1,
   input wire logic pop,
   output logic space,
   output logic head_valid,
   output tssv_pkg::res_type head
);

   tssv_pkg::res_type q_ff [4];
   tssv_pkg::res_type q_in [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in, wp_next;
   logic [2:0] cnt_ff, cnt_in;

   assign space = (cnt_ff <= 3'd2);
   assign head_valid = (cnt_ff != 3'd0);
   assign head = q_ff[rp_ff];
   assign wp_next = wp_ff + 2'd1;

   always_comb begin
      q_in = q_ff;
      if (push_count != 2'd0) q_in[wp_ff] = push0;
      if (push_count == 2'd2) q_in[wp_next] = push1;
      wp_in = wp_ff + push_count;
      rp_in = rp_ff + {1'b0, (pop && head_valid)};
      cnt_in = cnt_ff + {1'b0, push_count} - {2'd0, (pop && head_valid)};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wp_ff <= 2'd0;
         rp_ff <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/traffic_snapshot_stream_validator.sv @@
// Path: an accepted word is held in the input register, its results are written into the
// result queue, and the queue head is offered on the result channel.
// Throughput: one word per cycle; an end-of-file word that closes a pending line gives
// two results, and the four-entry result queue decides when input stalls.
// Reset: synchronous, active high; it returns all parser state to a fresh snapshot.
`default_nettype none
module traffic_snapshot_stream_validator (
   input wire logic clock,
   input wire logic reset,
   tssv_req_if.sink req_if,
   tssv_rsp_if.source rsp_if
);

   logic in_v_ff, in_v_in;
   logic [7:0] byte_ff, byte_in;
   logic eof_ff, eof_in;
   logic consume, space, head_valid;
   logic [1:0] res_count;
   tssv_pkg::res_type res0, res1, head;

   assign consume = in_v_ff && space;
   assign req_if.ready = !in_v_ff || consume;

   always_comb begin
      in_v_in = in_v_ff;
      byte_in = byte_ff;
      eof_in = eof_ff;
      if (req_if.ready) begin
         in_v_in = req_if.valid;
         byte_in = req_if.data_byte;
         eof_in = req_if.end_of_file;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eof_ff <= eof_in;
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   tssv_parse u_parse (
      .clock(clock),
      .reset(reset),
      .take(consume),
      .data_byte(byte_ff),
      .end_of_file(eof_ff),
      .res_count(res_count),
      .res0(res0),
      .res1(res1)
   );

   tssv_rspq u_rspq (
      .clock(clock),
      .reset(reset),
      .push_count(res_count),
      .push0(res0),
      .push1(res1),
      .pop(rsp_if.ready),
      .space(space),
      .head_valid(head_valid),
      .head(head)
   );

   assign rsp_if.valid = head_valid;
   assign rsp_if.line_kind = head.line_kind;
   assign rsp_if.line_ok = head.line_ok;
   assign rsp_if.rec_year = head.rec_year;
   assign rsp_if.rec_month = head.rec_month;
   assign rsp_if.rec_day = head.rec_day;
   assign rsp_if.upload_kb = head.upload_kb;
   assign rsp_if.download_kb = head.download_kb;
   assign rsp_if.mixed_count = head.mixed_count;
   assign rsp_if.is_verdict = head.is_verdict;
   assign rsp_if.snapshot_valid = head.snapshot_valid;

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_verdict) |->
         (rsp_if.line_kind == tssv_pkg::KIND_HEADER && !rsp_if.line_ok &&
          rsp_if.upload_kb == 64'd0 && rsp_if.download_kb == 64'd0))
      else $error("verdict word carries line fields");

   a_line_no_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.is_verdict) |-> !rsp_if.snapshot_valid)
      else $error("line word carries a verdict");

   a_reject_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.line_kind == tssv_pkg::KIND_REJECT) |-> !rsp_if.line_ok)
      else $error("rejected line marked good");

endmodule
`default_nettype wire
